>>> hdl/wct_pkg.sv
// Package for the weighted curve tangent unit: operation and register codes,
// fixed field widths and the divider request and response types. No dependencies.
`default_nettype none

package wct_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [2:0] REG_CURVE_LENGTH = 3'd7;

    localparam int NUM_W  = 39;
    localparam int DEN_W  = 19;
    localparam int QUO_W  = 20;

    typedef struct packed {
        logic              valid;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quo;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> hdl/weighted_curve_tangent_unit.sv
// Weighted curve tangent unit: point memory, tap sequencer and normaliser.
// Depends on wct_pkg and wct_div.
//
//   channel   handshake              payload
//   request   start / busy           operation point_index point_y point_x
//                                    use_forward use_backward range_start range_end
//   config    cfg_valid / cfg_ready  cfg_index cfg_data
//   result    result_valid (strobe)  tangent_y tangent_x out_of_range
//
// Load: accepted while idle, busy stays low. Evaluate: fetch the centre point,
// read and accumulate each tap, close each side and merge it, up to four
// divides, scaling, squaring, a root search for each of y and x and a finish
// step; an out-of-range index goes straight to finish. Result strobe in the
// cycle busy falls; the receiver cannot stall. Async active-low reset; memory
// is not cleared.
`default_nettype none

module weighted_curve_tangent_unit
    import wct_pkg::*;
#(
    parameter int KERNEL_TAPS = 8,
    parameter int MAX_POINTS  = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               operation,
    input  wire logic [9:0]         point_index,
    input  wire logic [11:0]        point_y,
    input  wire logic [11:0]        point_x,
    input  wire logic               use_forward,
    input  wire logic               use_backward,
    input  wire logic [9:0]         range_start,
    input  wire logic [10:0]        range_end,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    result_valid,
    output logic signed [15:0]      tangent_y,
    output logic signed [15:0]      tangent_x,
    output logic                    out_of_range
);

    localparam int AW = $clog2(MAX_POINTS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CTR_RD, ST_CTR_CAP, ST_TAP_RD, ST_TAP_ACC, ST_PART,
        ST_DIVY_GO, ST_DIVY_WAIT, ST_DIVX_GO, ST_DIVX_WAIT, ST_MERGE,
        ST_CHECK, ST_SCALE, ST_SQY, ST_SQX, ST_NORM_INIT, ST_NORM, ST_FINISH
    } state_t;

    state_t state_reg;

    logic [23:0]  mem [MAX_POINTS];
    logic [23:0]  rdata_reg;
    logic [AW-1:0] rd_addr;
    logic [10:0]  addr11;

    logic [15:0]  tw_reg [7];
    logic [10:0]  len_reg;
    logic [10:0]  len_eff;
    logic [10:0]  end_in;

    logic [9:0]   idx_reg;
    logic [9:0]   rs_reg;
    logic [10:0]  end_reg;
    logic         fwd_reg;
    logic         bwd_reg;
    logic         dir_reg;
    logic [3:0]   j_reg;
    logic [11:0]  pcy_reg;
    logic [11:0]  pcx_reg;
    logic [18:0]  sw_reg;
    logic [30:0]  sy_reg;
    logic [30:0]  sx_reg;
    logic [19:0]  my_reg;
    logic [19:0]  mx_reg;
    logic signed [21:0] ty_reg;
    logic signed [21:0] tx_reg;
    logic [20:0]  ay_reg;
    logic [20:0]  ax_reg;
    logic [29:0]  sqy_reg;
    logic [29:0]  sqx_reg;
    logic signed [65:0] p_reg;
    logic signed [65:0] a_reg;
    logic signed [65:0] b_reg;
    logic signed [65:0] r_reg;
    logic [3:0]   k_reg;
    logic [14:0]  n_reg;
    logic         comp_reg;
    logic [14:0]  magy_reg;
    logic [14:0]  magx_reg;
    logic         oor_reg;
    logic         rv_reg;
    logic signed [15:0] toy_reg;
    logic signed [15:0] tox_reg;

    logic         take;
    logic         tap_ok;
    logic [15:0]  w_cur;
    logic [27:0]  wpy;
    logic [27:0]  wpx;
    logic [14:0]  sq_in;
    logic [29:0]  sq;
    logic [30:0]  s_sum;
    logic signed [65:0] trial;
    logic [14:0]  n_next;
    logic signed [21:0] dy;
    logic signed [21:0] dx;
    logic signed [21:0] pmy;
    logic signed [21:0] pmx;
    logic [14:0]  fin_y;
    logic [14:0]  fin_x;
    div_req_t     dreq;
    div_rsp_t     drsp;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign take      = start && !busy;

    assign len_eff = (17'(len_reg) < 17'(MAX_POINTS)) ? len_reg : 11'(MAX_POINTS);
    assign end_in  = (range_end == 11'd0 || range_end > len_eff) ? len_eff : range_end;

    assign tap_ok = (dir_reg ? fwd_reg : bwd_reg) && (j_reg < 4'(KERNEL_TAPS)) &&
                    (dir_reg ? ({1'b0, idx_reg} + 11'(j_reg) < end_reg)
                             : ({1'b0, idx_reg} >= 11'(j_reg) + {1'b0, rs_reg}));

    always_comb
    begin
        case (state_reg)
            ST_TAP_RD: addr11 = dir_reg ? ({1'b0, idx_reg} + 11'(j_reg))
                                        : ({1'b0, idx_reg} - 11'(j_reg));
            default:   addr11 = {1'b0, idx_reg};
        endcase
    end
    assign rd_addr = AW'(addr11);

    always_ff @(posedge clk)
    begin
        if (take && operation == OP_LOAD && 17'(point_index) < 17'(MAX_POINTS))
        begin
            mem[AW'(point_index)] <= {point_y, point_x};
        end
        rdata_reg <= mem[rd_addr];
    end

    assign w_cur = tw_reg[3'(j_reg - 4'd1)];
    assign wpy   = w_cur * rdata_reg[23:12];
    assign wpx   = w_cur * rdata_reg[11:0];

    assign sq_in = (state_reg == ST_SQY) ? ay_reg[14:0] : ax_reg[14:0];
    assign sq    = sq_in * sq_in;
    assign s_sum = {1'b0, sqy_reg} + {1'b0, sqx_reg};

    assign trial  = p_reg + a_reg + b_reg;
    assign n_next = (trial <= r_reg) ? (n_reg | (15'd1 << k_reg)) : n_reg;

    assign pmy = $signed({2'b0, pcy_reg, 8'b0});
    assign pmx = $signed({2'b0, pcx_reg, 8'b0});
    assign dy  = dir_reg ? ($signed({2'b0, my_reg}) - pmy) : (pmy - $signed({2'b0, my_reg}));
    assign dx  = dir_reg ? ($signed({2'b0, mx_reg}) - pmx) : (pmx - $signed({2'b0, mx_reg}));

    assign fin_y = magy_reg;
    assign fin_x = magx_reg;

    always_comb
    begin
        dreq.valid = (state_reg == ST_DIVY_GO) || (state_reg == ST_DIVX_GO);
        dreq.num   = ((state_reg == ST_DIVY_GO) ? {sy_reg, 8'b0} : {sx_reg, 8'b0})
                     + NUM_W'(sw_reg >> 1);
        dreq.den   = sw_reg;
    end

    wct_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int t = 0; t < 7; t++)
            begin
                tw_reg[t] <= '0;
            end
            len_reg  <= '0;
            idx_reg  <= '0;
            rs_reg   <= '0;
            end_reg  <= '0;
            fwd_reg  <= 1'b0;
            bwd_reg  <= 1'b0;
            dir_reg  <= 1'b0;
            j_reg    <= '0;
            pcy_reg  <= '0;
            pcx_reg  <= '0;
            sw_reg   <= '0;
            sy_reg   <= '0;
            sx_reg   <= '0;
            my_reg   <= '0;
            mx_reg   <= '0;
            ty_reg   <= '0;
            tx_reg   <= '0;
            ay_reg   <= '0;
            ax_reg   <= '0;
            sqy_reg  <= '0;
            sqx_reg  <= '0;
            p_reg    <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            r_reg    <= '0;
            k_reg    <= '0;
            n_reg    <= '0;
            comp_reg <= 1'b0;
            magy_reg <= '0;
            magx_reg <= '0;
            oor_reg  <= 1'b0;
            rv_reg   <= 1'b0;
            toy_reg  <= '0;
            tox_reg  <= '0;
        end
        else
        begin
            rv_reg <= 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == REG_CURVE_LENGTH)
                begin
                    len_reg <= cfg_data[10:0];
                end
                else
                begin
                    tw_reg[cfg_index] <= cfg_data;
                end
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take && operation == OP_EVAL)
                    begin
                        idx_reg  <= point_index;
                        rs_reg   <= range_start;
                        end_reg  <= end_in;
                        fwd_reg  <= use_forward;
                        bwd_reg  <= use_backward;
                        ty_reg   <= '0;
                        tx_reg   <= '0;
                        magy_reg <= '0;
                        magx_reg <= '0;
                        if ({1'b0, point_index} >= len_eff)
                        begin
                            oor_reg   <= 1'b1;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            oor_reg   <= 1'b0;
                            state_reg <= ST_CTR_RD;
                        end
                    end
                end
                ST_CTR_RD:
                begin
                    state_reg <= ST_CTR_CAP;
                end
                ST_CTR_CAP:
                begin
                    pcy_reg   <= rdata_reg[23:12];
                    pcx_reg   <= rdata_reg[11:0];
                    dir_reg   <= 1'b0;
                    j_reg     <= 4'd1;
                    sw_reg    <= '0;
                    sy_reg    <= '0;
                    sx_reg    <= '0;
                    state_reg <= ST_TAP_RD;
                end
                ST_TAP_RD:
                begin
                    state_reg <= tap_ok ? ST_TAP_ACC : ST_PART;
                end
                ST_TAP_ACC:
                begin
                    sw_reg    <= sw_reg + 19'(w_cur);
                    sy_reg    <= sy_reg + 31'(wpy);
                    sx_reg    <= sx_reg + 31'(wpx);
                    j_reg     <= j_reg + 4'd1;
                    state_reg <= ST_TAP_RD;
                end
                ST_PART:
                begin
                    if (sw_reg != '0)
                    begin
                        state_reg <= ST_DIVY_GO;
                    end
                    else if (!dir_reg)
                    begin
                        dir_reg   <= 1'b1;
                        j_reg     <= 4'd1;
                        state_reg <= ST_TAP_RD;
                    end
                    else
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_DIVY_GO:
                begin
                    state_reg <= ST_DIVY_WAIT;
                end
                ST_DIVY_WAIT:
                begin
                    if (drsp.done)
                    begin
                        my_reg    <= drsp.quo;
                        state_reg <= ST_DIVX_GO;
                    end
                end
                ST_DIVX_GO:
                begin
                    state_reg <= ST_DIVX_WAIT;
                end
                ST_DIVX_WAIT:
                begin
                    if (drsp.done)
                    begin
                        mx_reg    <= drsp.quo;
                        state_reg <= ST_MERGE;
                    end
                end
                ST_MERGE:
                begin
                    ty_reg <= ty_reg + dy;
                    tx_reg <= tx_reg + dx;
                    sw_reg <= '0;
                    sy_reg <= '0;
                    sx_reg <= '0;
                    if (!dir_reg)
                    begin
                        dir_reg   <= 1'b1;
                        j_reg     <= 4'd1;
                        state_reg <= ST_TAP_RD;
                    end
                    else
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    ay_reg <= 21'(ty_reg[21] ? -ty_reg : ty_reg);
                    ax_reg <= 21'(tx_reg[21] ? -tx_reg : tx_reg);
                    state_reg <= (ty_reg == '0 && tx_reg == '0) ? ST_FINISH : ST_SCALE;
                end
                ST_SCALE:
                begin
                    if (ay_reg[20:15] != '0 || ax_reg[20:15] != '0)
                    begin
                        ay_reg <= ay_reg >> 1;
                        ax_reg <= ax_reg >> 1;
                    end
                    else
                    begin
                        state_reg <= ST_SQY;
                    end
                end
                ST_SQY:
                begin
                    sqy_reg   <= sq;
                    state_reg <= ST_SQX;
                end
                ST_SQX:
                begin
                    sqx_reg   <= sq;
                    comp_reg  <= 1'b0;
                    state_reg <= ST_NORM_INIT;
                end
                ST_NORM_INIT:
                begin
                    p_reg <= $signed(66'(s_sum));
                    a_reg <= -$signed(66'(s_sum) << 16);
                    b_reg <= $signed(66'(s_sum) << 30);
                    r_reg <= $signed(66'(comp_reg ? sqx_reg : sqy_reg) << 30);
                    k_reg <= 4'd14;
                    n_reg <= '0;
                    state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    if (trial <= r_reg)
                    begin
                        p_reg <= trial;
                        a_reg <= (a_reg + (b_reg <<< 1)) >>> 1;
                    end
                    else
                    begin
                        a_reg <= a_reg >>> 1;
                    end
                    b_reg <= b_reg >>> 2;
                    n_reg <= n_next;
                    k_reg <= k_reg - 4'd1;
                    if (k_reg == 4'd0)
                    begin
                        if (!comp_reg)
                        begin
                            magy_reg  <= n_next;
                            comp_reg  <= 1'b1;
                            state_reg <= ST_NORM_INIT;
                        end
                        else
                        begin
                            magx_reg  <= n_next;
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    rv_reg    <= 1'b1;
                    toy_reg   <= ty_reg[21] ? -$signed({1'b0, fin_y}) : $signed({1'b0, fin_y});
                    tox_reg   <= tx_reg[21] ? -$signed({1'b0, fin_x}) : $signed({1'b0, fin_x});
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = rv_reg;
    assign tangent_y    = toy_reg;
    assign tangent_x    = tox_reg;
    assign out_of_range = oor_reg;

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_LOAD) |=> !result_valid)
        else $error("load produced a result");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && out_of_range) |-> (tangent_y == '0 && tangent_x == '0))
        else $error("out of range result not zero");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == ST_DIVY_WAIT || state_reg == ST_DIVX_WAIT))
        else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

>>> hdl/wct_div.sv
// Restoring divider, one quotient bit per cycle, for the weighted means.
// Depends on wct_pkg. Quotient must fit in QUO_W bits.
`default_nettype none

module wct_div
    import wct_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] low_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [4:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg, low_reg[QUO_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            low_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.valid)
            begin
                rem_reg <= req.num[NUM_W-1:QUO_W];
                low_reg <= req.num[QUO_W-1:0];
                den_reg <= req.den;
                cnt_reg <= 5'(QUO_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[DEN_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                low_reg <= {low_reg[QUO_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

>>> tb/tb_weighted_curve_tangent_unit.sv
// Testbench for weighted_curve_tangent_unit: loads curve points, sweeps tap
// weights and curve lengths, and checks every tangent against a local predictor.
// Depends on wct_pkg and the unit's RTL.
`timescale 1ns / 1ps

typedef struct {
    logic signed [15:0] ty;
    logic signed [15:0] tx;
    logic               oor;
} tangent_t;

class TangentScoreboard;
    tangent_t pending[$];
    int       mismatches;

    function new();
        mismatches = 0;
    endfunction

    function void note_request(tangent_t t);
        pending = {pending, t};
    endfunction

    function void check_result(logic signed [15:0] ty, logic signed [15:0] tx, logic oor);
        tangent_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result ty=%0d tx=%0d oor=%0b", ty, tx, oor);
            return;
        end
        e = pending.pop_front();
        if (e.ty !== ty || e.tx !== tx || e.oor !== oor) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp ty=%0d tx=%0d oor=%0b, got ty=%0d tx=%0d oor=%0b",
                         e.ty, e.tx, e.oor, ty, tx, oor);
        end
    endfunction
endclass

module tb_weighted_curve_tangent_unit;
    import wct_pkg::*;

    localparam logic [2:0] REG_TAP_FIRST = 3'd0;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         SETTLE_CYCLES  = 200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               operation = OP_LOAD;
    logic [9:0]         point_index = '0;
    logic [11:0]        point_y = '0;
    logic [11:0]        point_x = '0;
    logic               use_forward = 1'b0;
    logic               use_backward = 1'b0;
    logic [9:0]         range_start = '0;
    logic [10:0]        range_end = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               result_valid;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_x;
    logic               out_of_range;

    weighted_curve_tangent_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .point_index(point_index), .point_y(point_y),
        .point_x(point_x), .use_forward(use_forward), .use_backward(use_backward),
        .range_start(range_start), .range_end(range_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .tangent_y(tangent_y),
        .tangent_x(tangent_x), .out_of_range(out_of_range)
    );

    always #5 clk = ~clk;

    TangentScoreboard sb = new();

    logic [11:0] mem_y [1024];
    logic [11:0] mem_x [1024];
    bit          loaded [1024];
    logic [15:0] tap_w [8];
    logic [10:0] len_reg;
    bit          calm;
    int          quiet_cycles;

    function automatic longint mean_q8(longint unsigned swp, longint unsigned sw);
        return longint'((swp * 256 + sw / 2) / sw);
    endfunction

    function automatic longint unsigned unit_magnitude(longint unsigned a, longint unsigned s);
        longint unsigned lo, hi, mid, d, rhs;
        lo = 0;
        hi = 16384;
        rhs = (a * a) << 30;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            d = 2 * mid - 1;
            if (d * d * s <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic tangent_t predict_tangent(int idx, bit fwd, bit bwd, int rs, int re);
        tangent_t        r;
        int              n, stop, j;
        longint          ty, tx;
        longint unsigned sw, sy, sx, ay, ax, s, my, mx;
        r.ty = '0;
        r.tx = '0;
        r.oor = 1'b0;
        ty = 0;
        tx = 0;
        n = (len_reg < 1024) ? len_reg : 1024;
        if (idx >= n) begin
            r.oor = 1'b1;
            return r;
        end
        stop = (re == 0 || re > n) ? n : re;
        if (bwd) begin
            sw = 0; sy = 0; sx = 0;
            for (j = 1; j < 8 && idx >= j + rs; j++) begin
                sy += tap_w[j] * mem_y[idx - j];
                sx += tap_w[j] * mem_x[idx - j];
                sw += tap_w[j];
            end
            if (sw != 0) begin
                ty += longint'(mem_y[idx]) * 256 - mean_q8(sy, sw);
                tx += longint'(mem_x[idx]) * 256 - mean_q8(sx, sw);
            end
        end
        if (fwd) begin
            sw = 0; sy = 0; sx = 0;
            for (j = 1; j < 8 && idx + j < stop; j++) begin
                sy += tap_w[j] * mem_y[idx + j];
                sx += tap_w[j] * mem_x[idx + j];
                sw += tap_w[j];
            end
            if (sw != 0) begin
                ty += mean_q8(sy, sw) - longint'(mem_y[idx]) * 256;
                tx += mean_q8(sx, sw) - longint'(mem_x[idx]) * 256;
            end
        end
        if (ty == 0 && tx == 0) return r;
        ay = (ty < 0) ? -ty : ty;
        ax = (tx < 0) ? -tx : tx;
        while (ay >= 32768 || ax >= 32768) begin
            ay >>= 1;
            ax >>= 1;
        end
        s = ay * ay + ax * ax;
        my = unit_magnitude(ay, s);
        mx = unit_magnitude(ax, s);
        r.ty = (ty < 0) ? -16'(my) : 16'(my);
        r.tx = (tx < 0) ? -16'(mx) : 16'(mx);
        return r;
    endfunction

    always @(posedge clk) begin
        if (rst_n && result_valid)
            sb.check_result(tangent_y, tangent_x, out_of_range);
    end

    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("weighted_curve_tangent_unit verification failed");
            $finish;
        end
    end

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_request(logic op, int idx, int y, int x, bit fwd, bit bwd,
                                int rs, int re);
        tangent_t t;
        maybe_pause();
        start <= 1'b1;
        operation <= op;
        point_index <= idx[9:0];
        point_y <= y[11:0];
        point_x <= x[11:0];
        use_forward <= fwd;
        use_backward <= bwd;
        range_start <= rs[9:0];
        range_end <= re[10:0];
        do @(posedge clk); while (busy);
        if (op == OP_LOAD) begin
            mem_y[idx] = y[11:0];
            mem_x[idx] = x[11:0];
            loaded[idx] = 1'b1;
        end else begin
            t = predict_tangent(idx, fwd, bwd, rs, re);
            sb.note_request(t);
        end
    endtask

    task automatic load_point(int idx, int y, int x);
        send_request(OP_LOAD, idx, y, x, 1'b0, 1'b0, 0, 0);
    endtask

    task automatic eval_at(int idx, bit fwd, bit bwd, int rs, int re);
        send_request(OP_EVAL, idx, 0, 0, fwd, bwd, rs, re);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_CURVE_LENGTH) len_reg = value[10:0];
        else tap_w[idx - REG_TAP_FIRST + 1] = value[15:0];
    endtask

    task automatic set_taps(int mode);
        int k, w;
        for (k = 0; k < 7; k++) begin
            case (mode)
                0: w = 0;
                1: w = 65535;
                2: w = (k == 0) ? 65535 : 0;
                default: w = ($urandom_range(0, 5) == 0) ? 0 :
                             ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 65535);
            endcase
            write_reg(REG_TAP_FIRST + 3'(k), w);
        end
    endtask

    task automatic fill_curve(int n);
        int k;
        for (k = 0; k < n; k++)
            if (!loaded[k]) load_point(k, $urandom_range(0, 4095), $urandom_range(0, 4095));
    endtask

    task automatic fill_window(int idx, int n);
        int k, lo, hi;
        lo = (idx > 7) ? idx - 7 : 0;
        hi = (idx + 7 < n) ? idx + 7 : n - 1;
        for (k = lo; k <= hi; k++)
            if (!loaded[k]) load_point(k, $urandom_range(0, 4095), $urandom_range(0, 4095));
    endtask

    task automatic random_items(int count);
        int k, idx, rs, re, n, span;
        n = len_reg;
        span = (n < 32) ? n : 32;
        for (k = 0; k < count; k++) begin
            if (k == count / 2) wait_drained();
            if ($urandom_range(0, 99) < 20) begin
                idx = $urandom_range(0, 1023);
                load_point(idx, $urandom_range(0, 4095), $urandom_range(0, 4095));
            end else begin
                if (n > 0 && $urandom_range(0, 99) < 85)
                    idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, span - 1)
                                                      : $urandom_range(n - span, n - 1);
                else
                    idx = (n < 1024) ? $urandom_range(n, 1023) : $urandom_range(0, 1023);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: rs = 0;
                    5, 6, 7: rs = (idx > 8) ? idx - $urandom_range(0, 8) : 0;
                    default: rs = $urandom_range(0, 1023);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2: re = 0;
                    3, 4: re = 1024;
                    5, 6, 7: re = (idx + 8 < 1024) ? idx + $urandom_range(0, 8) : 1024;
                    default: re = $urandom_range(0, 1024);
                endcase
                if (idx < n) fill_window(idx, n);
                eval_at(idx, $urandom_range(0, 1), $urandom_range(0, 1), rs, re);
            end
        end
    endtask

    initial begin
        int p, n;
        foreach (loaded[k]) loaded[k] = 1'b0;
        foreach (tap_w[k]) tap_w[k] = '0;
        len_reg = '0;
        calm = 1'b0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length, zero taps
        eval_at(0, 1'b1, 1'b1, 0, 0);
        eval_at(1023, 1'b1, 1'b1, 1023, 1024);
        settle();
        set_taps(2);
        write_reg(REG_CURVE_LENGTH, 16);
        load_point(0, 0, 0);
        load_point(1, 4095, 4095);
        load_point(2, 4095, 0);
        load_point(3, 0, 4095);
        fill_curve(16);
        load_point(1023, 4095, 4095);
        eval_at(0, 1'b1, 1'b1, 0, 0);
        eval_at(1, 1'b1, 1'b1, 0, 0);
        eval_at(2, 1'b0, 1'b1, 0, 0);
        eval_at(2, 1'b1, 1'b0, 0, 1024);
        eval_at(5, 1'b0, 1'b0, 0, 0);
        eval_at(5, 1'b0, 1'b1, 9, 0);
        eval_at(15, 1'b1, 1'b1, 0, 3);
        eval_at(16, 1'b1, 1'b1, 0, 0);
        settle();
        set_taps(1);
        load_point(4, 100, 100);
        load_point(5, 100, 100);
        load_point(6, 100, 100);
        eval_at(5, 1'b1, 1'b1, 4, 7);
        eval_at(8, 1'b1, 1'b1, 0, 0);
        settle();
        set_taps(0);
        eval_at(8, 1'b1, 1'b1, 0, 0);
        settle();

        for (p = 0; p < 8; p++) begin
            calm = (p == 3);
            case (p)
                0: n = 1;
                1: n = 1024;
                2: n = 8;
                3: n = $urandom_range(16, 200);
                4: n = 2;
                default: n = $urandom_range(1, 1024);
            endcase
            set_taps((p == 1) ? 1 : 3);
            write_reg(REG_CURVE_LENGTH, n);
            random_items(35);
            settle();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("weighted_curve_tangent_unit verification clean");
        else
            $display("weighted_curve_tangent_unit verification failed");
        $finish;
    end
endmodule
